[design/cjt_pkg.sv]
// ----------------------------------------------------------------------------
// cjt_pkg
// Shared types and constants of the cubic joint trajectory block.
// ----------------------------------------------------------------------------
`default_nettype none

package cjt_pkg;

    localparam int ANGLE_W   = 8;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int U_W       = 17;
    localparam int SQ_W      = 33;
    localparam int ACC_W     = 48;
    localparam int CNT_W     = 5;

    localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;
    localparam logic [DUR_W-1:0] DUR_MIN   = 16'd1;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd15;
    localparam logic [CNT_W-1:0] MUL_LAST  = 5'd16;
    localparam logic [U_W-1:0]   BLEND_ONE = 17'h10000;
    localparam logic [U_W-1:0]   B_BASE    = 17'd98304;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_WAIT,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        BL_IDLE,
        BL_DIV,
        BL_SQ,
        BL_MUL,
        BL_DONE
    } blend_state_t;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] elapsed;
        logic [DUR_W-1:0] dur;
    } blend_req_t;

    typedef struct packed {
        logic           done;
        logic [U_W-1:0] blend;
    } blend_rsp_t;

endpackage

`default_nettype wire

[design/cjt_blend.sv]
// ----------------------------------------------------------------------------
// cjt_blend
// Serial unit: u = elapsed*2^16/dur by restoring division, one bit a cycle,
// then blend = u^2*(3*2^15 - u) / 2^31 by a shift-add multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cjt_blend (
    input  wire                  clk,
    input  wire                  rst_n,
    input  cjt_pkg::blend_req_t  req,
    output cjt_pkg::blend_rsp_t  rsp
);

    cjt_pkg::blend_state_t state_reg, state_next;

    logic [cjt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [cjt_pkg::DUR_W-1:0] dur_reg, dur_next;
    logic [cjt_pkg::U_W-1:0]   rem_reg, rem_next;
    logic [cjt_pkg::U_W-1:0]   u_reg, u_next;
    logic [cjt_pkg::SQ_W-1:0]  sq_reg, sq_next;
    logic [cjt_pkg::U_W-1:0]   b_reg, b_next;
    logic [cjt_pkg::ACC_W-1:0] acc_reg, acc_next;

    logic [cjt_pkg::U_W-1:0]   rem_dbl;
    logic                      rem_ge;
    logic [2*cjt_pkg::U_W-1:0] u_sq;

    assign rem_dbl = {rem_reg[cjt_pkg::U_W-2:0], 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, dur_reg};
    assign u_sq    = u_reg * u_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cjt_pkg::BL_IDLE:
            begin
                if (req.start)
                begin
                    if (req.elapsed == req.dur)
                        state_next = cjt_pkg::BL_SQ;
                    else
                        state_next = cjt_pkg::BL_DIV;
                end
            end
            cjt_pkg::BL_DIV:
            begin
                if (cnt_reg == cjt_pkg::DIV_LAST)
                    state_next = cjt_pkg::BL_SQ;
            end
            cjt_pkg::BL_SQ:
                state_next = cjt_pkg::BL_MUL;
            cjt_pkg::BL_MUL:
            begin
                if (cnt_reg == cjt_pkg::MUL_LAST)
                    state_next = cjt_pkg::BL_DONE;
            end
            cjt_pkg::BL_DONE:
                state_next = cjt_pkg::BL_IDLE;
            default:
                state_next = cjt_pkg::BL_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next = cnt_reg;
        dur_next = dur_reg;
        rem_next = rem_reg;
        u_next   = u_reg;
        sq_next  = sq_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        case (state_reg)
            cjt_pkg::BL_IDLE:
            begin
                cnt_next = '0;
                dur_next = req.dur;
                rem_next = {1'b0, req.elapsed};
                if (req.elapsed == req.dur)
                    u_next = cjt_pkg::BLEND_ONE;
                else
                    u_next = '0;
            end
            cjt_pkg::BL_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (rem_ge)
                    rem_next = rem_dbl - {1'b0, dur_reg};
                else
                    rem_next = rem_dbl;
                u_next = {u_reg[cjt_pkg::U_W-2:0], rem_ge};
            end
            cjt_pkg::BL_SQ:
            begin
                cnt_next = '0;
                sq_next  = u_sq[cjt_pkg::SQ_W-1:0];
                b_next   = cjt_pkg::B_BASE - u_reg;
                acc_next = '0;
            end
            cjt_pkg::BL_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                b_next   = {b_reg[cjt_pkg::U_W-2:0], 1'b0};
                if (b_reg[cjt_pkg::U_W-1])
                    acc_next = {acc_reg[cjt_pkg::ACC_W-2:0], 1'b0}
                             + cjt_pkg::ACC_W'(sq_reg);
                else
                    acc_next = {acc_reg[cjt_pkg::ACC_W-2:0], 1'b0};
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done  = state_reg == cjt_pkg::BL_DONE;
    assign rsp.blend = acc_reg[cjt_pkg::ACC_W-1:cjt_pkg::ACC_W-cjt_pkg::U_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cjt_pkg::BL_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg <= dur_next;
        rem_reg <= rem_next;
        u_reg   <= u_next;
        sq_reg  <= sq_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    a_rem_below_dur: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cjt_pkg::BL_DIV |-> rem_reg < {1'b0, dur_reg})
        else $error("division remainder not below divisor");

    a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> rsp.blend <= cjt_pkg::BLEND_ONE)
        else $error("blend above one");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == cjt_pkg::BL_IDLE)
        else $error("blend started while busy");

endmodule

`default_nettype wire

[design/cubic_joint_trajectory.sv]
// ----------------------------------------------------------------------------
// cubic_joint_trajectory
// Per-joint cubic move profile: start + (target - start)*(3u^2 - 2u^3).
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request word: joint in tuser, start angle, target
//   angle and millisecond time stamp in tdata. m_axis returns one word per
//   request: angle in 1/256 degree in tdata, move-done flag in tuser.
//   cfg_we/cfg_wdata write the move duration in ms (0 acts as 1).
//   a new target for a joint restarts its move at the given time stamp.
//   path from accept to m_axis_tvalid: once the move is over the target
//   angle goes straight out; when elapsed equals duration only the 17-step
//   shift-add multiplier runs, otherwise the 16-step divider runs before it.
//   one word is worked at a time; the next is taken once the result sits in
//   the output register.
//   a stalled m_axis holds its word; one more result may finish behind it
//   and waits until the output register frees.
//   reset: duration 1000 ms, stored targets and start times zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_joint_trajectory #(
    parameter int NUM_JOINTS = 3
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata,     // duration_ms
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,  // start_angle, target_angle, now_ms
    input  wire  [1:0]  s_axis_tuser,  // joint
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // angle_q8
    output logic        m_axis_tuser   // move_done
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic [3:0] JMAX = 4'(NUM_JOINTS - 1);

    cjt_pkg::top_state_t state_reg, state_next;

    logic [cjt_pkg::DUR_W-1:0]   dur_cfg_reg;
    logic [JW-1:0]               idx_reg;
    logic [cjt_pkg::ANGLE_W-1:0] start_reg;
    logic [cjt_pkg::ANGLE_W-1:0] tgt_reg;
    logic [cjt_pkg::TIME_W-1:0]  now_reg;
    logic [cjt_pkg::ANGLE_W-1:0] last_tgt_reg [NUM_JOINTS];
    logic [cjt_pkg::TIME_W-1:0]  mst_reg [NUM_JOINTS];
    logic [15:0]                 res_angle_reg, res_angle_next;
    logic                        res_done_reg, res_done_next;
    logic                        m_valid_reg, m_valid_next;
    logic [15:0]                 m_data_reg;
    logic                        m_user_reg;

    logic                        accept;
    logic [3:0]                  jwide;
    logic [3:0]                  jsel;
    logic [cjt_pkg::DUR_W-1:0]   dur_eff;
    logic                        restart;
    logic [cjt_pkg::TIME_W-1:0]  elapsed;
    logic                        late;
    logic                        out_load;
    logic signed [8:0]           diff_s;
    logic signed [17:0]          blend_s;
    logic signed [26:0]          prod;
    logic signed [26:0]          sum;

    cjt_pkg::blend_req_t blend_req;
    cjt_pkg::blend_rsp_t blend_rsp;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign jwide   = {2'b00, s_axis_tuser};
    assign jsel    = (jwide > JMAX) ? JMAX : jwide;
    assign dur_eff = (dur_cfg_reg == '0) ? cjt_pkg::DUR_MIN : dur_cfg_reg;
    assign restart = last_tgt_reg[idx_reg] != tgt_reg;
    assign elapsed = restart ? '0 : now_reg - mst_reg[idx_reg];
    assign late    = elapsed > {16'b0, dur_eff};

    assign diff_s  = $signed({1'b0, tgt_reg}) - $signed({1'b0, start_reg});
    assign blend_s = $signed({1'b0, blend_rsp.blend});
    assign prod    = 27'(diff_s) * 27'(blend_s);
    assign sum     = $signed({3'b000, start_reg, 16'h0000}) + prod;

    cjt_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .rsp   (blend_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cjt_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = cjt_pkg::ST_PREP;
            end
            cjt_pkg::ST_PREP:
            begin
                if (late)
                    state_next = cjt_pkg::ST_OUT;
                else
                    state_next = cjt_pkg::ST_WAIT;
            end
            cjt_pkg::ST_WAIT:
            begin
                if (blend_rsp.done)
                    state_next = cjt_pkg::ST_OUT;
            end
            cjt_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = cjt_pkg::ST_IDLE;
            end
            default:
                state_next = cjt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready     = state_reg == cjt_pkg::ST_IDLE;
        blend_req.start   = (state_reg == cjt_pkg::ST_PREP) && !late;
        blend_req.elapsed = elapsed[cjt_pkg::DUR_W-1:0];
        blend_req.dur     = dur_eff;
        out_load          = (state_reg == cjt_pkg::ST_OUT)
                          && (!m_valid_reg || m_axis_tready);
        res_angle_next    = res_angle_reg;
        res_done_next     = res_done_reg;
        case (state_reg)
            cjt_pkg::ST_PREP:
            begin
                res_angle_next = {tgt_reg, 8'h00};
                res_done_next  = 1'b1;
            end
            cjt_pkg::ST_WAIT:
            begin
                if (blend_rsp.done)
                begin
                    res_angle_next = sum[23:8];
                    res_done_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cjt_pkg::ST_IDLE;
            dur_cfg_reg <= cjt_pkg::DUR_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                last_tgt_reg[i] <= '0;
                mst_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
                dur_cfg_reg <= cfg_wdata;
            if ((state_reg == cjt_pkg::ST_PREP) && restart)
            begin
                last_tgt_reg[idx_reg] <= tgt_reg;
                mst_reg[idx_reg]      <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= jsel[JW-1:0];
            start_reg <= s_axis_tdata[7:0];
            tgt_reg   <= s_axis_tdata[15:8];
            now_reg   <= s_axis_tdata[47:16];
        end
        res_angle_reg <= res_angle_next;
        res_done_reg  <= res_done_next;
        if (out_load)
        begin
            m_data_reg <= res_angle_reg;
            m_user_reg <= res_done_reg;
        end
    end

    a_done_on_target: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
        else $error("finished move not on a whole degree");

    a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        blend_rsp.done |-> state_reg == cjt_pkg::ST_WAIT)
        else $error("blend result outside wait state");

    a_elapsed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        blend_req.start |-> blend_req.elapsed <= blend_req.dur)
        else $error("blend started past the duration");

endmodule

`default_nettype wire
